[rtl/core/tlts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tlts_pkg;

  // Fixed field widths
  localparam int ADDR_W          = 32;
  localparam int EV_TAG_W        = 18;
  localparam int CNT_W           = 32;
  localparam int WAYS            = 2;

  // Defaults for the top-level parameters
  localparam int SETS_DEF        = 256;
  localparam int OFFSET_BITS_DEF = 6;

  // One access beat
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              is_write;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic                hit;
    logic                way_used;
    logic                dirty_evicted;
    logic [EV_TAG_W-1:0] evicted_tag;
    logic [CNT_W-1:0]    access_count;
    logic [CNT_W-1:0]    hit_count;
    logic [CNT_W-1:0]    writeback_count;
  } out_beat_t;

  // Per-set status word kept in the status RAM
  typedef struct packed {
    logic            lru;
    logic [WAYS-1:0] valid;
    logic [WAYS-1:0] dirty;
  } set_status_t;

  // Lookup outcome handed from the lookup logic to the top level
  typedef struct packed {
    logic                hit;
    logic                way;
    logic                dirty_ev;
    logic [EV_TAG_W-1:0] ev_tag;
  } lookup_res_t;

endpackage

`default_nettype wire

[rtl/core/two_way_lru_cache_tag_store_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Beat moves when
// -------   -----------------------------  --------------------------------
// access    start, busy, in_data           start && !busy at rising clk
// result    out_valid, out_data            out_valid high (one cycle, no stall)
//
// While busy is low one access is taken every cycle. The taking edge also
// reads the tag and status RAMs; the next edge loads the compare/update
// outcome into out_data, so the result is strobed for the cycle after it.
// Throughput is set by the single read and write port of the tag and status
// RAMs; a back-to-back access to the same set is served by forwarding.
// After reset the status RAM is swept clean, set by set, with busy high.
// The result side cannot stall: each result is shown for exactly one cycle.
module two_way_lru_cache_tag_store_unit #(
  parameter int SETS        = tlts_pkg::SETS_DEF,
  parameter int OFFSET_BITS = tlts_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tlts_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  output tlts_pkg::out_beat_t      out_data
);

  import tlts_pkg::*;

  localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W = ADDR_W - OFFSET_BITS - IDX_W;
  localparam int ST_W  = $bits(set_status_t);
  localparam logic [IDX_W:0]   SETS_EXT = (IDX_W+1)'(SETS);
  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SETS - 1);

  // Address split for the incoming beat
  logic              accept;
  logic [IDX_W-1:0]  idx_field;
  logic [IDX_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;

  // Lookup stage
  logic              s1_valid_r;
  logic [IDX_W-1:0]  s1_set_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic              s1_wr_r;
  logic              fwd_r;
  set_status_t       fwd_st_r;
  logic [2*TAG_W-1:0] fwd_tags_r;

  logic [2*TAG_W-1:0] tag_q;
  logic [ST_W-1:0]    st_q;
  set_status_t        st_cur;
  logic [2*TAG_W-1:0] tags_cur;
  set_status_t        st_nxt;
  logic [2*TAG_W-1:0] tags_nxt;
  lookup_res_t        lk_res;

  // Clearing sweep
  logic              clr_active_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [ST_W-1:0]   st_wdata;

  // Counters and result register
  logic [CNT_W-1:0]  acc_cnt_r;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic [CNT_W-1:0]  wb_cnt_r;
  logic [CNT_W-1:0]  acc_cnt_nxt;
  logic [CNT_W-1:0]  hit_cnt_nxt;
  logic [CNT_W-1:0]  wb_cnt_nxt;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  assign busy   = clr_active_r;
  assign accept = start && !clr_active_r;

  // Index wraps modulo SETS; the field is below twice SETS
  assign idx_field = in_data.address[OFFSET_BITS +: IDX_W];
  assign in_set    = ({1'b0, idx_field} >= SETS_EXT) ?
                     IDX_W'({1'b0, idx_field} - SETS_EXT) : idx_field;
  assign in_tag    = in_data.address[ADDR_W-1 -: TAG_W];

  // Tag RAM: never cleared, tags only looked at under valid
  tlts_ram #(
    .WIDTH (2*TAG_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_set_r),
    .wdata (tags_nxt),
    .raddr (in_set),
    .rdata (tag_q)
  );

  // Status RAM: valid, dirty and LRU per set, swept after reset
  assign st_we    = clr_active_r || s1_valid_r;
  assign st_waddr = clr_active_r ? clr_idx_r : s1_set_r;
  assign st_wdata = clr_active_r ? '0 : st_nxt;

  tlts_ram #(
    .WIDTH (ST_W),
    .DEPTH (SETS)
  ) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (in_set),
    .rdata (st_q)
  );

  // Forwarded row wins when the previous beat updated the same set
  assign st_cur   = fwd_r ? fwd_st_r : set_status_t'(st_q);
  assign tags_cur = fwd_r ? fwd_tags_r : tag_q;

  tlts_lookup #(
    .TAG_W (TAG_W)
  ) u_lookup (
    .tags       (tags_cur),
    .status     (st_cur),
    .tag        (s1_tag_r),
    .is_write   (s1_wr_r),
    .res        (lk_res),
    .status_nxt (st_nxt),
    .tags_nxt   (tags_nxt)
  );

  // Input register and forwarding capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      fwd_r      <= accept && s1_valid_r && (s1_set_r == in_set);
    end
    s1_set_r   <= in_set;
    s1_tag_r   <= in_tag;
    s1_wr_r    <= in_data.is_write;
    fwd_st_r   <= st_nxt;
    fwd_tags_r <= tags_nxt;
  end

  // Status RAM sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == LAST_SET) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // Saturating counters
  assign acc_cnt_nxt = (&acc_cnt_r) ? acc_cnt_r : acc_cnt_r + 1'b1;
  assign hit_cnt_nxt = (lk_res.hit && !(&hit_cnt_r)) ? hit_cnt_r + 1'b1 : hit_cnt_r;
  assign wb_cnt_nxt  = (lk_res.dirty_ev && !(&wb_cnt_r)) ? wb_cnt_r + 1'b1 : wb_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= '0;
      hit_cnt_r <= '0;
      wb_cnt_r  <= '0;
    end else if (s1_valid_r) begin
      acc_cnt_r <= acc_cnt_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      wb_cnt_r  <= wb_cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
    out_data_r.hit             <= lk_res.hit;
    out_data_r.way_used        <= lk_res.way;
    out_data_r.dirty_evicted   <= lk_res.dirty_ev;
    out_data_r.evicted_tag     <= lk_res.ev_tag;
    out_data_r.access_count    <= acc_cnt_nxt;
    out_data_r.hit_count       <= hit_cnt_nxt;
    out_data_r.writeback_count <= wb_cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // No access is in flight while the sweep runs
  a_no_work_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r && !fwd_r)
    else $error("access in flight during status sweep");

  // Every taken beat gives a result through the lookup stage and the result register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("missing result for accepted access");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hit |->
      !out_data_r.dirty_evicted && (out_data_r.evicted_tag == '0))
    else $error("hit reported an eviction");

  // Hits and writebacks never outrun accesses
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hit_count <= out_data_r.access_count) &&
                    (out_data_r.writeback_count <= out_data_r.access_count))
    else $error("counter ordering broken");

  // The sweep does not restart outside reset
  a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_active_r |=> !clr_active_r)
    else $error("status sweep restarted");

endmodule

`default_nettype wire

[rtl/core/tlts_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/tlts_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

module tlts_lookup #(
  parameter int TAG_W = 18
) (
  input  wire logic [2*TAG_W-1:0]         tags,
  input  wire tlts_pkg::set_status_t      status,
  input  wire logic [TAG_W-1:0]           tag,
  input  wire logic                       is_write,
  output tlts_pkg::lookup_res_t           res,
  output tlts_pkg::set_status_t           status_nxt,
  output logic      [2*TAG_W-1:0]         tags_nxt
);

  import tlts_pkg::*;

  logic [TAG_W-1:0]          tag0;
  logic [TAG_W-1:0]          tag1;
  logic                      match0;
  logic                      match1;
  logic                      hit;
  logic                      way;
  logic [TAG_W-1:0]          victim_tag;
  logic                      dirty_ev;
  logic [TAG_W+EV_TAG_W-1:0] ev_wide;

  assign tag0 = tags[TAG_W-1:0];
  assign tag1 = tags[2*TAG_W-1:TAG_W];

  // Parallel compare of both ways; way 0 wins a double match
  assign match0 = status.valid[0] && (tag0 == tag);
  assign match1 = status.valid[1] && (tag1 == tag);
  assign hit    = match0 || match1;
  assign way    = match0 ? 1'b0 : (match1 ? 1'b1 : status.lru);

  // Victim on a miss
  assign victim_tag = way ? tag1 : tag0;
  assign dirty_ev   = !hit && status.valid[way] && status.dirty[way];
  assign ev_wide    = {{EV_TAG_W{1'b0}}, victim_tag};

  assign res.hit      = hit;
  assign res.way      = way;
  assign res.dirty_ev = dirty_ev;
  assign res.ev_tag   = dirty_ev ? ev_wide[EV_TAG_W-1:0] : '0;

  // Next status and tags for the set
  always_comb begin
    status_nxt     = status;
    tags_nxt       = tags;
    status_nxt.lru = ~way;
    if (hit) begin
      if (is_write) begin
        status_nxt.dirty[way] = 1'b1;
      end
    end else begin
      status_nxt.valid[way] = 1'b1;
      status_nxt.dirty[way] = is_write;
      if (way) begin
        tags_nxt[2*TAG_W-1:TAG_W] = tag;
      end else begin
        tags_nxt[TAG_W-1:0] = tag;
      end
    end
  end

endmodule

`default_nettype wire
